[sv/cvh_pkg.sv]
// shared types and constants of the convex hull block
package cvh_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// one stored point, x in the low half and y in the high half
	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} point_t;

	// kind of test done by the geometry unit
	typedef enum logic {
		GEO_BEFORE,
		GEO_TURN
	} geo_mode_t;

	typedef struct packed {
		logic      start;
		geo_mode_t mode;
	} geo_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic res;
	} geo_rsp_t;

endpackage

[sv/cvh_pt_if.sv]
// request channel carrying input points
interface cvh_pt_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic               last_point;

	modport source (output valid, output x_coord, output y_coord, output last_point,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input last_point,
		output ready);
endinterface

[sv/cvh_hull_if.sv]
// request channel carrying hull vertices
interface cvh_hull_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] hull_x;
	logic signed [15:0] hull_y;
	logic               last_vertex;
	logic               points_dropped;

	modport source (output valid, output hull_x, output hull_y, output last_vertex,
		output points_dropped, input ready);
	modport sink (input valid, input hull_x, input hull_y, input last_vertex,
		input points_dropped, output ready);
endinterface

[sv/convex_hull_graham_scan.sv]
// Graham scan convex hull over a stored point set
//
// Points arrive on pts, one per accepted request; the request with
// last_point set closes the set. Up to 64 points are kept in the point
// memory, later points are dropped and points_dropped is raised on every
// vertex of that set. While the set is processed pts.ready stays low.
// The hull leaves on hull in counter-clockwise order, last_vertex on the
// final vertex. Sets of one or two points come out as given.
// Loading accepts one point per cycle. Sorting is an in-place insertion sort
// in the memory: each comparison reads the single read port and uses the
// shared geometry unit, and each point placed is written back to memory.
// The scan reads the two top stack entries and the next point for each
// turn test, and each vertex is read from memory and held until hull.ready.
// A stalled receiver simply holds the current vertex; nothing is lost.
// Reset empties the set and returns to loading at once; the memory needs
// no clearing.
module convex_hull_graham_scan (
	input logic          clk,
	input logic          arst_n,
	cvh_pt_if.sink       pts,
	cvh_hull_if.source   hull
);

	typedef enum logic [3:0] {
		LOAD, S_RT, S_RT2, S_RJ, S_RJ2, S_CW, S_WT,
		SC_R0, SC_R1, SC_R2, SC_R3, SC_W, SC_PUSH,
		E_RD, E_LD, E_WAIT
	} state_t;

	localparam logic [cvh_pkg::CNT_W-1:0] CNT_MAX = cvh_pkg::CNT_W'(cvh_pkg::MAX_POINTS);
	localparam logic [cvh_pkg::CNT_W-1:0] CNT_ONE = cvh_pkg::CNT_W'(1);
	localparam logic [cvh_pkg::CNT_W-1:0] CNT_TWO = cvh_pkg::CNT_W'(2);

	state_t                     state_q;
	logic [cvh_pkg::CNT_W-1:0]  n_q, i_q, j_q, sp_q, k_q, hcnt_q;
	logic                       ovf_q;
	cvh_pkg::point_t            piv_q, t_q, m_q, a_q, b_q, c_q;
	logic signed [15:0]         hx_q, hy_q;
	logic                       hlast_q, hdrop_q, hvalid_q;

	logic                       we;
	logic [cvh_pkg::ADDR_W-1:0] waddr, raddr;
	cvh_pkg::point_t            wdata, rdata, in_pt;
	cvh_pkg::geo_req_t          greq;
	cvh_pkg::geo_rsp_t          grsp;
	cvh_pkg::point_t            ga, gb;
	logic                       acc, store, new_min;
	logic [cvh_pkg::CNT_W-1:0]  n_next, jm1, spm1, spm2;

	assign acc     = pts.valid && pts.ready;
	assign store   = n_q < CNT_MAX;
	assign in_pt   = '{y: pts.y_coord, x: pts.x_coord};
	assign new_min = (n_q == '0) || (pts.y_coord < piv_q.y) ||
		(pts.y_coord == piv_q.y && pts.x_coord < piv_q.x);
	assign n_next  = store ? n_q + CNT_ONE : n_q;
	assign jm1     = j_q - CNT_ONE;
	assign spm1    = sp_q - CNT_ONE;
	assign spm2    = sp_q - CNT_TWO;

	cvh_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	cvh_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (greq),
		.pa     (ga),
		.pb     (gb),
		.pc     (rdata),
		.rsp    (grsp)
	);

	// memory port and geometry request steering
	always_comb begin
		we         = 1'b0;
		waddr      = n_q[cvh_pkg::ADDR_W-1:0];
		wdata      = in_pt;
		raddr      = i_q[cvh_pkg::ADDR_W-1:0];
		greq.start = 1'b0;
		greq.mode  = cvh_pkg::GEO_BEFORE;
		ga         = piv_q;
		gb         = t_q;
		unique case (state_q)
			LOAD: we = acc && store;
			S_RJ, S_RJ2: raddr = jm1[cvh_pkg::ADDR_W-1:0];
			S_CW: begin
				we    = grsp.done && grsp.res;
				waddr = j_q[cvh_pkg::ADDR_W-1:0];
				wdata = m_q;
			end
			S_WT: begin
				we    = 1'b1;
				waddr = j_q[cvh_pkg::ADDR_W-1:0];
				wdata = t_q;
			end
			SC_R0: raddr = spm2[cvh_pkg::ADDR_W-1:0];
			SC_R1: raddr = spm1[cvh_pkg::ADDR_W-1:0];
			SC_PUSH: begin
				we    = 1'b1;
				waddr = sp_q[cvh_pkg::ADDR_W-1:0];
				wdata = c_q;
			end
			E_RD, E_LD, E_WAIT: raddr = k_q[cvh_pkg::ADDR_W-1:0];
			default: ;
		endcase
		if (state_q == S_RJ2) begin
			greq.start = 1'b1;
		end
		if (state_q == SC_R3) begin
			greq.start = 1'b1;
			greq.mode  = cvh_pkg::GEO_TURN;
			ga         = a_q;
			gb         = b_q;
		end
	end

	// main sequencer: load, sort, scan, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LOAD;
			n_q      <= '0;
			ovf_q    <= 1'b0;
			hcnt_q   <= '0;
			hvalid_q <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			sp_q     <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (acc) begin
						n_q <= n_next;
						if (!store) ovf_q <= 1'b1;
						if (store && new_min) piv_q <= in_pt;
						if (pts.last_point) begin
							k_q <= '0;
							if (n_next <= CNT_TWO) begin
								hcnt_q  <= n_next;
								state_q <= E_RD;
							end else begin
								i_q     <= CNT_ONE;
								state_q <= S_RT;
							end
						end
					end
				end
				S_RT: state_q <= S_RT2;
				S_RT2: begin
					t_q     <= rdata;
					j_q     <= i_q;
					state_q <= S_RJ;
				end
				S_RJ: state_q <= S_RJ2;
				S_RJ2: begin
					m_q     <= rdata;
					state_q <= S_CW;
				end
				S_CW: begin
					if (grsp.done) begin
						if (grsp.res) begin
							j_q     <= jm1;
							state_q <= (j_q == CNT_ONE) ? S_WT : S_RJ;
						end else begin
							state_q <= S_WT;
						end
					end
				end
				S_WT: begin
					if (i_q + CNT_ONE == n_q) begin
						sp_q    <= CNT_TWO;
						i_q     <= CNT_TWO;
						state_q <= SC_R0;
					end else begin
						i_q     <= i_q + CNT_ONE;
						state_q <= S_RT;
					end
				end
				SC_R0: state_q <= SC_R1;
				SC_R1: begin
					a_q     <= rdata;
					state_q <= SC_R2;
				end
				SC_R2: begin
					b_q     <= rdata;
					state_q <= SC_R3;
				end
				SC_R3: begin
					c_q     <= rdata;
					state_q <= SC_W;
				end
				SC_W: begin
					if (grsp.done) begin
						if (grsp.res) begin
							sp_q    <= spm1;
							state_q <= (spm1 > CNT_ONE) ? SC_R0 : SC_PUSH;
						end else begin
							state_q <= SC_PUSH;
						end
					end
				end
				SC_PUSH: begin
					sp_q <= sp_q + CNT_ONE;
					if (i_q + CNT_ONE == n_q) begin
						hcnt_q  <= sp_q + CNT_ONE;
						k_q     <= '0;
						state_q <= E_RD;
					end else begin
						i_q     <= i_q + CNT_ONE;
						state_q <= SC_R0;
					end
				end
				E_RD: state_q <= E_LD;
				E_LD: begin
					hx_q     <= rdata.x;
					hy_q     <= rdata.y;
					hlast_q  <= (k_q + CNT_ONE == hcnt_q);
					hdrop_q  <= ovf_q;
					hvalid_q <= 1'b1;
					state_q  <= E_WAIT;
				end
				E_WAIT: begin
					if (hull.ready) begin
						hvalid_q <= 1'b0;
						k_q      <= k_q + CNT_ONE;
						if (hlast_q) begin
							n_q     <= '0;
							ovf_q   <= 1'b0;
							state_q <= LOAD;
						end else begin
							state_q <= E_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign pts.ready           = state_q == LOAD;
	assign hull.valid          = hvalid_q;
	assign hull.hull_x         = hx_q;
	assign hull.hull_y         = hy_q;
	assign hull.last_vertex    = hlast_q;
	assign hull.points_dropped = hdrop_q;

	// the hull stack never grows past the point being scanned
	a_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SC_W) |-> (sp_q <= i_q && sp_q > CNT_ONE))
		else $error("hull stack pointer out of range");

	// the sort cursor stays inside the sorted prefix
	a_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CW) |-> (j_q >= CNT_ONE && j_q <= i_q))
		else $error("sort cursor out of range");

	// no test is started while the geometry unit is busy
	a_geo: assert property (@(posedge clk) disable iff (!arst_n)
		greq.start |-> !grsp.busy)
		else $error("geometry unit started while busy");

	// closing a set stops further points
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pts.last_point) |=> !pts.ready)
		else $error("point accepted after set was closed");

endmodule

[sv/cvh_ram.sv]
// point memory, one write port and one registered read port
module cvh_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [cvh_pkg::ADDR_W-1:0]  waddr,
	input  cvh_pkg::point_t             wdata,
	input  logic [cvh_pkg::ADDR_W-1:0]  raddr,
	output cvh_pkg::point_t             rdata
);

	cvh_pkg::point_t mem [cvh_pkg::MAX_POINTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/cvh_geom.sv]
// multi-cycle orientation and distance test about point a
module cvh_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  cvh_pkg::geo_req_t req,
	input  cvh_pkg::point_t   pa,
	input  cvh_pkg::point_t   pb,
	input  cvh_pkg::point_t   pc,
	output cvh_pkg::geo_rsp_t rsp
);

	typedef enum logic [2:0] {
		G_IDLE, G_MUL1, G_SUB, G_MUL2, G_MUL3, G_CMP
	} gstate_t;

	gstate_t            state_q;
	cvh_pkg::geo_mode_t mode_q;
	logic signed [16:0] dbx_q, dby_q, dcx_q, dcy_q;
	logic signed [33:0] p1_q, p2_q;
	logic signed [34:0] cr_q, da_q;
	logic               done_q, res_q;

	// difference vectors are taken when a test starts
	always_ff @(posedge clk) begin
		if (req.start && state_q == G_IDLE) begin
			dbx_q  <= 17'(pb.x) - 17'(pa.x);
			dby_q  <= 17'(pb.y) - 17'(pa.y);
			dcx_q  <= 17'(pc.x) - 17'(pa.x);
			dcy_q  <= 17'(pc.y) - 17'(pa.y);
			mode_q <= req.mode;
		end
	end

	// sequencer: two products per cycle, then subtract or compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			res_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: begin
					if (req.start) state_q <= G_MUL1;
				end
				G_MUL1: begin
					p1_q    <= dbx_q * dcy_q;
					p2_q    <= dby_q * dcx_q;
					state_q <= G_SUB;
				end
				G_SUB: begin
					cr_q    <= 35'(p1_q) - 35'(p2_q);
					state_q <= G_MUL2;
				end
				G_MUL2: begin
					if (mode_q == cvh_pkg::GEO_TURN) begin
						res_q   <= cr_q < 0;
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else if (cr_q != 0) begin
						res_q   <= cr_q > 0;
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else begin
						p1_q    <= dbx_q * dbx_q;
						p2_q    <= dby_q * dby_q;
						state_q <= G_MUL3;
					end
				end
				G_MUL3: begin
					da_q    <= 35'(p1_q) + 35'(p2_q);
					p1_q    <= dcx_q * dcx_q;
					p2_q    <= dcy_q * dcy_q;
					state_q <= G_CMP;
				end
				G_CMP: begin
					res_q   <= da_q < (35'(p1_q) + 35'(p2_q));
					done_q  <= 1'b1;
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign rsp.busy = state_q != G_IDLE;
	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

[bench/convex_hull_graham_scan_tb.sv]
// self-checking bench for the Graham scan convex hull block
`timescale 1ns / 1ps

module convex_hull_graham_scan_tb;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} pt_req_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic               dropped;
	} vertex_t;

	logic clk;
	logic arst_n;

	cvh_pt_if   pts();
	cvh_hull_if hull();

	convex_hull_graham_scan u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts.sink),
		.hull   (hull.source)
	);

	// predictor state
	logic signed [15:0] set_x[cvh_pkg::MAX_POINTS];
	logic signed [15:0] set_y[cvh_pkg::MAX_POINTS];
	int                 set_cnt;
	logic               set_over = 1'b0;

	pt_req_t pending_pts[$];
	vertex_t hull_expected[$];
	int      errors;
	int      cycles;
	int      vertices_seen;
	int      sets_closed;
	bit      long_stall_req;
	int      long_stall_left;
	int      burst_left;
	int      gap_left;
	bit      pts_taken;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cross product of (b - a) and (c - a)
	function automatic longint cross3(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
	endfunction

	function automatic bit sorts_ahead(longint ox, longint oy, longint ax, longint ay,
		longint bx, longint by);
		longint c;
		longint da;
		longint db;
		c = cross3(ox, oy, ax, ay, bx, by);
		if (c != 0) return c > 0;
		da = (ax - ox) * (ax - ox) + (ay - oy) * (ay - oy);
		db = (bx - ox) * (bx - ox) + (by - oy) * (by - oy);
		return da < db;
	endfunction

	// accept one point into the predictor, emit the hull when the set closes
	task automatic predict_point(pt_req_t p);
		longint  hx[cvh_pkg::MAX_POINTS];
		longint  hy[cvh_pkg::MAX_POINTS];
		longint  ox;
		longint  oy;
		longint  tx;
		longint  ty;
		int      n;
		int      j;
		int      k;
		vertex_t v;
		if (set_cnt < cvh_pkg::MAX_POINTS) begin
			set_x[set_cnt] = p.x;
			set_y[set_cnt] = p.y;
			set_cnt++;
		end else begin
			set_over = 1'b1;
		end
		if (!p.last) return;
		n = set_cnt;
		for (int i = 0; i < n; i++) begin
			hx[i] = set_x[i];
			hy[i] = set_y[i];
		end
		k = n;
		if (n > 2) begin
			ox = hx[0];
			oy = hy[0];
			for (int i = 1; i < n; i++) begin
				if (hy[i] < oy || (hy[i] == oy && hx[i] < ox)) begin
					ox = hx[i];
					oy = hy[i];
				end
			end
			for (int i = 1; i < n; i++) begin
				tx = hx[i];
				ty = hy[i];
				j = i;
				while (j > 0 && sorts_ahead(ox, oy, tx, ty, hx[j-1], hy[j-1])) begin
					hx[j] = hx[j-1];
					hy[j] = hy[j-1];
					j--;
				end
				hx[j] = tx;
				hy[j] = ty;
			end
			k = 2;
			for (int i = 2; i < n; i++) begin
				while (k > 1 && cross3(hx[k-2], hy[k-2], hx[k-1], hy[k-1],
					hx[i], hy[i]) < 0) k--;
				hx[k] = hx[i];
				hy[k] = hy[i];
				k++;
			end
		end
		for (int i = 0; i < k; i++) begin
			v.x = hx[i][15:0];
			v.y = hy[i][15:0];
			v.last = (i + 1 == k);
			v.dropped = set_over;
			hull_expected.insert(hull_expected.size(), v);
		end
		set_cnt = 0;
		set_over = 1'b0;
		sets_closed++;
	endtask

	function automatic pt_req_t mk(int x, int y, bit last);
		pt_req_t p;
		p.x = x[15:0];
		p.y = y[15:0];
		p.last = last;
		return p;
	endfunction

	// append one point request to the stimulus queue
	task automatic queue_pt(pt_req_t p);
		pending_pts.insert(pending_pts.size(), p);
	endtask

	function automatic logic [15:0] rnd_coord(int span);
		int r;
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: begin
				r = $urandom_range(0, 2 * span);
				return 16'(r - span);
			end
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: begin
				r = $urandom_range(0, 8);
				return 16'(r - 4);
			end
		endcase
	endfunction

	// driver: bursts and gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid      <= 1'b0;
			pts.x_coord    <= '0;
			pts.y_coord    <= '0;
			pts.last_point <= 1'b0;
			burst_left     <= 0;
			gap_left       <= 0;
		end else if (!(pts.valid && !pts_taken)) begin
			if (pending_pts.size() == 0) begin
				pts.valid <= 1'b0;
			end else if (gap_left > 0) begin
				pts.valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else begin
				pts.valid      <= 1'b1;
				pts.x_coord    <= pending_pts[0].x;
				pts.y_coord    <= pending_pts[0].y;
				pts.last_point <= pending_pts[0].last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// request acceptance seen at the rising edge
	always @(posedge clk) begin
		pts_taken <= 1'b0;
		if (arst_n && pts.valid && pts.ready) begin
			pts_taken <= 1'b1;
			predict_point(pending_pts.pop_front());
		end
	end

	// receiver stall pattern, with a long hold-off on demand
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull.ready      <= 1'b0;
			long_stall_left <= 0;
		end else if (long_stall_req && long_stall_left == 0) begin
			long_stall_left <= 30000;
			hull.ready      <= 1'b0;
		end else if (long_stall_left > 1) begin
			long_stall_left <= long_stall_left - 1;
			hull.ready      <= 1'b0;
		end else begin
			if (long_stall_left == 1) long_stall_left <= long_stall_left - 1;
			case ((cycles / 256) % 3)
				0: hull.ready <= 1'b1;
				1: hull.ready <= ($urandom_range(0, 3) != 0);
				default: hull.ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// monitor: compare each accepted vertex with the oldest expectation
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && hull.valid && hull.ready) begin
			vertices_seen++;
			if (hull_expected.size() == 0) begin
				$error("unexpected vertex x=%0d y=%0d", hull.hull_x, hull.hull_y);
				errors++;
			end else begin
				e = hull_expected.pop_front();
				if (hull.hull_x !== e.x) begin
					$error("hull_x expected %0d actual %0d", e.x, hull.hull_x);
					errors++;
				end
				if (hull.hull_y !== e.y) begin
					$error("hull_y expected %0d actual %0d", e.y, hull.hull_y);
					errors++;
				end
				if (hull.last_vertex !== e.last) begin
					$error("last_vertex expected %0b actual %0b", e.last, hull.last_vertex);
					errors++;
				end
				if (hull.points_dropped !== e.dropped) begin
					$error("points_dropped expected %0b actual %0b", e.dropped,
						hull.points_dropped);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_set(int n, int span, bit hulled);
		int r;
		for (int i = 0; i < n; i++) begin
			if (hulled && i < 4) begin
				r = $urandom_range(1, span);
				queue_pt(mk((i[0] ? r : -r), (i[1] ? r : -r), i == n - 1));
			end else begin
				queue_pt(mk($signed(rnd_coord(span)), $signed(rnd_coord(span)),
					i == n - 1));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_pts.size() != 0 || hull_expected.size() != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int total;
		long_stall_req = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed: single point, two points, extremes, collinear and duplicates
		queue_pt(mk(32767, -32768, 1));
		queue_pt(mk(-32768, 32767, 0));
		queue_pt(mk(5, 5, 1));
		queue_pt(mk(-32768, -32768, 0));
		queue_pt(mk(32767, -32768, 0));
		queue_pt(mk(32767, 32767, 0));
		queue_pt(mk(-32768, 32767, 0));
		queue_pt(mk(0, 0, 1));
		queue_pt(mk(0, 0, 0));
		queue_pt(mk(2, 0, 0));
		queue_pt(mk(1, 0, 0));
		queue_pt(mk(2, 2, 0));
		queue_pt(mk(1, 1, 0));
		queue_pt(mk(0, 2, 0));
		queue_pt(mk(0, 2, 0));
		queue_pt(mk(1, 1, 1));
		queue_pt(mk(3, 3, 0));
		queue_pt(mk(3, 3, 0));
		queue_pt(mk(3, 3, 1));
		wait_drained();

		// overflow: a full store plus dropped points, last one dropped
		for (int i = 0; i < cvh_pkg::MAX_POINTS + 3; i++)
			queue_pt(mk(i * 7 - 200, (i * i) % 97 - 50, i == cvh_pkg::MAX_POINTS + 2));
		// long receiver hold-off while the sender keeps offering
		long_stall_req = 1'b1;
		push_set(6, 100, 1'b1);
		push_set(3, 20, 1'b0);
		@(posedge clk);
		long_stall_req = 1'b0;
		wait_drained();

		// random sets, the sender sometimes pausing until every vertex is out
		total = 0;
		while (total < 35) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			push_set(n, $urandom_range(0, 1) ? 10 : 30000, $urandom_range(0, 3) != 0);
			total += n;
			if ($urandom_range(0, 3) == 0) wait_drained();
		end
		wait_drained();
		repeat (200) @(posedge clk);

		$display("closed %0d point sets, checked %0d hull vertices", sets_closed,
			vertices_seen);
		$display("covered tiny sets, extremes, collinear, duplicates and overflow");
		if (errors == 0 && hull_expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[convex_hull_graham_scan.f]
sv/cvh_pkg.sv
sv/cvh_pt_if.sv
sv/cvh_hull_if.sv
sv/cvh_ram.sv
sv/cvh_geom.sv
sv/convex_hull_graham_scan.sv
bench/convex_hull_graham_scan_tb.sv
